FILE: design/ece_pkg.sv
// Shared constants, types and saturating arithmetic for the cell energy engine.
`default_nettype none
package ece_pkg;
	localparam int GROUP_COUNT_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int MAT_DIM         = 6;
	localparam int MAT_WORDS       = 36;
	localparam int STAGES          = 16;

	localparam logic [5:0] OP_COMPUTE   = 6'd0;
	localparam logic [5:0] OP_C_FIRST   = 6'd1;
	localparam logic [5:0] OP_C_LAST    = 6'd36;
	localparam logic [5:0] OP_DENSITY   = 6'd37;

	typedef struct packed {
		logic vld;
		logic ok;
		logic last;
		logic sat;
	} meta_t;

	typedef struct packed {
		logic               ov;
		logic signed [63:0] v;
	} sat64_t;

	typedef struct packed {
		logic               ov;
		logic signed [31:0] v;
	} nar_t;

	function automatic sat64_t sat_add(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		sat64_t r;
		s = {a[63], a} + {b[63], b};
		r.ov = s[64] ^ s[63];
		if (!r.ov) begin
			r.v = s[63:0];
		end else if (s[64]) begin
			r.v = {1'b1, 63'd0};
		end else begin
			r.v = {1'b0, {63{1'b1}}};
		end
		return r;
	endfunction

	// Arithmetic shift right by sh, then clamp to the 32-bit signed range.
	function automatic nar_t narrow(logic signed [63:0] x, int sh);
		logic signed [63:0] r;
		nar_t o;
		r = x >>> sh;
		if (r > 64'sh0000_0000_7FFF_FFFF) begin
			o.ov = 1'b1;
			o.v  = 32'sh7FFF_FFFF;
		end else if (r < -64'sh0000_0000_8000_0000) begin
			o.ov = 1'b1;
			o.v  = 32'sh8000_0000;
		end else begin
			o.ov = 1'b0;
			o.v  = r[31:0];
		end
		return o;
	endfunction
endpackage
`default_nettype wire

FILE: design/elastic_cell_energy.sv
// Throughput: one transaction per cycle while the output is not stalled; loads write the
// table rows and produce no result. The table read is a registered row read, followed by
// multiplier and narrowing stages and saturating 64-bit adds, one add per stage. The whole
// pipeline holds when the output stalls. Reset clears only the per-stage metadata flags
// (valid, ok, last, saturated); table contents are undefined until loaded.
`default_nettype none
module elastic_cell_energy #(
	parameter int GROUP_COUNT = ece_pkg::GROUP_COUNT_DEF,
	parameter int FRAC_BITS   = ece_pkg::FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// opcode[5:0], group_index[9:6], sol_0..sol_8 [297:10] 32 bits each, zero pad [303:298]
	input  wire logic [303:0] s_tdata,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// energy[63:0], saturated[64], zero pad [71:65]
	output logic [71:0]       m_tdata,
	output logic              m_tlast
);
	import ece_pkg::*;

	localparam int AW  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int SH  = 32 - 2 * FRAC_BITS;
	localparam int SHL = (SH > 0) ? SH : 0;
	localparam int SHR = (SH < 0) ? -SH : 0;

	logic        en, acc_in, ok_in;
	logic [5:0]  opcode;
	logic [3:0]  group_index;
	logic [AW-1:0] addr;
	logic signed [31:0] sol [9];

	assign opcode      = s_tdata[5:0];
	assign group_index = s_tdata[9:6];
	for (genvar g = 0; g < 9; g++) begin : g_sol
		assign sol[g] = s_tdata[10 + 32*g +: 32];
	end
	assign addr   = AW'(group_index);
	assign ok_in  = (32'(group_index) < GROUP_COUNT);
	assign en     = !meta[STAGES].vld || m_tready;
	assign s_tready = en;
	assign acc_in = s_tvalid && s_tready;

	logic [31:0] rd_c [MAT_WORDS];
	logic [31:0] rd_rho;

	ece_table #(.GROUP_COUNT(GROUP_COUNT), .AW(AW)) u_table (
		.clk    (clk),
		.c_we   (acc_in && ok_in && opcode >= OP_C_FIRST && opcode <= OP_C_LAST),
		.c_word (opcode - OP_C_FIRST),
		.r_we   (acc_in && ok_in && opcode == OP_DENSITY),
		.wr_addr(addr),
		.wr_data(sol[0]),
		.rd_en  (acc_in),
		.rd_addr(addr),
		.rd_c   (rd_c),
		.rd_rho (rd_rho)
	);

	// Stage payloads.
	logic signed [31:0] v_s1 [3];
	logic signed [31:0] s_s1 [MAT_DIM], s_s2 [MAT_DIM], s_s3 [MAT_DIM], s_s4 [MAT_DIM];
	logic signed [31:0] s_s5 [MAT_DIM], s_s6 [MAT_DIM], s_s7 [MAT_DIM], s_s8 [MAT_DIM];
	logic signed [63:0] p_s2 [MAT_WORDS], p_s3 [MAT_WORDS], p_s4 [MAT_WORDS];
	logic signed [63:0] p_s5 [MAT_WORDS], p_s6 [MAT_WORDS];
	logic signed [63:0] q_s2 [3], q2_s3;
	logic signed [31:0] rho_s2, rho_s3, rho_s4, rho_s5;
	logic signed [63:0] t_s3 [MAT_DIM], t_s4 [MAT_DIM], t_s5 [MAT_DIM];
	logic signed [63:0] t_s6 [MAT_DIM], t_s7 [MAT_DIM];
	logic signed [63:0] vv_s3, vv_s4;
	logic signed [31:0] vvn_s5;
	logic signed [63:0] rv_s6, rv_s7, rv_s8;
	logic signed [31:0] stn_s8 [MAT_DIM];
	logic signed [63:0] m_s [9:14][MAT_DIM];
	logic signed [63:0] acc_s [9:15];
	logic [63:0]        energy_s16;

	meta_t meta [1:STAGES];
	logic [STAGES:2] sat_new;

	// Combinational results of each stage.
	sat64_t t3 [MAT_DIM], t4 [MAT_DIM], t5 [MAT_DIM], t6 [MAT_DIM], t7 [MAT_DIM];
	sat64_t vv3, vv4, a_add [10:15];
	nar_t   vvn5, stn8 [MAT_DIM];
	logic signed [63:0] half15, q32_16;
	logic               q32_ov;

	always_comb begin
		sat_new = '0;
		vv3 = sat_add(q_s2[0], q_s2[1]);
		vv4 = sat_add(vv_s3, q2_s3);
		vvn5 = narrow(vv_s4, FRAC_BITS);
		sat_new[3] = vv3.ov;
		sat_new[4] = vv4.ov;
		sat_new[5] = vvn5.ov;
		for (int i = 0; i < MAT_DIM; i++) begin
			t3[i] = sat_add(p_s2[i], p_s2[MAT_DIM + i]);
			t4[i] = sat_add(t_s3[i], p_s3[2*MAT_DIM + i]);
			t5[i] = sat_add(t_s4[i], p_s4[3*MAT_DIM + i]);
			t6[i] = sat_add(t_s5[i], p_s5[4*MAT_DIM + i]);
			t7[i] = sat_add(t_s6[i], p_s6[5*MAT_DIM + i]);
			stn8[i] = narrow(t_s7[i], FRAC_BITS);
			sat_new[3] = sat_new[3] | t3[i].ov;
			sat_new[4] = sat_new[4] | t4[i].ov;
			sat_new[5] = sat_new[5] | t5[i].ov;
			sat_new[6] = sat_new[6] | t6[i].ov;
			sat_new[7] = sat_new[7] | t7[i].ov;
			sat_new[8] = sat_new[8] | stn8[i].ov;
		end
		for (int k = 10; k <= 15; k++) begin
			a_add[k] = sat_add(acc_s[k-1], m_s[k-1][k-10]);
			sat_new[k] = a_add[k].ov;
		end
		half15 = acc_s[15] >>> 1;
		q32_ov = 1'b0;
		if (SH > 0) begin
			if (half15 > (64'sh7FFF_FFFF_FFFF_FFFF >>> SHL)) begin
				q32_ov = 1'b1;
				q32_16 = {1'b0, {63{1'b1}}};
			end else if (half15 < (64'sh8000_0000_0000_0000 >>> SHL)) begin
				q32_ov = 1'b1;
				q32_16 = {1'b1, 63'd0};
			end else begin
				q32_16 = half15 <<< SHL;
			end
		end else begin
			q32_16 = half15 >>> SHR;
		end
		sat_new[16] = q32_ov;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i] <= sol[i];
				q_s2[i] <= v_s1[i] * v_s1[i];
			end
			q2_s3 <= q_s2[2];
			for (int i = 0; i < MAT_DIM; i++) begin
				s_s1[i] <= sol[3 + i];
				s_s2[i] <= s_s1[i];
				s_s3[i] <= s_s2[i];
				s_s4[i] <= s_s3[i];
				s_s5[i] <= s_s4[i];
				s_s6[i] <= s_s5[i];
				s_s7[i] <= s_s6[i];
				s_s8[i] <= s_s7[i];
				t_s3[i] <= t3[i].v;
				t_s4[i] <= t4[i].v;
				t_s5[i] <= t5[i].v;
				t_s6[i] <= t6[i].v;
				t_s7[i] <= t7[i].v;
				stn_s8[i] <= stn8[i].v;
				m_s[9][i] <= s_s8[i] * stn_s8[i];
				for (int k = 10; k <= 14; k++) begin
					m_s[k][i] <= m_s[k-1][i];
				end
				for (int j = 0; j < MAT_DIM; j++) begin
					p_s2[j*MAT_DIM + i] <= $signed(rd_c[j*MAT_DIM + i]) * s_s1[j];
				end
			end
			for (int w = 0; w < MAT_WORDS; w++) begin
				p_s3[w] <= p_s2[w];
				p_s4[w] <= p_s3[w];
				p_s5[w] <= p_s4[w];
				p_s6[w] <= p_s5[w];
			end
			rho_s2 <= $signed(rd_rho);
			rho_s3 <= rho_s2;
			rho_s4 <= rho_s3;
			rho_s5 <= rho_s4;
			vv_s3  <= vv3.v;
			vv_s4  <= vv4.v;
			vvn_s5 <= vvn5.v;
			rv_s6  <= rho_s5 * vvn_s5;
			rv_s7  <= rv_s6;
			rv_s8  <= rv_s7;
			acc_s[9] <= rv_s8;
			for (int k = 10; k <= 15; k++) begin
				acc_s[k] <= a_add[k].v;
			end
			energy_s16 <= meta[15].ok ? q32_16 : 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= STAGES; k++) begin
				meta[k] <= '0;
			end
		end else if (en) begin
			meta[1] <= '{vld: acc_in && opcode == OP_COMPUTE, ok: ok_in, last: s_tlast,
				sat: 1'b0};
			for (int k = 2; k <= STAGES; k++) begin
				meta[k].vld  <= meta[k-1].vld;
				meta[k].ok   <= meta[k-1].ok;
				meta[k].last <= meta[k-1].last;
				meta[k].sat  <= meta[k-1].sat | (sat_new[k] & meta[k-1].ok);
			end
		end
	end

	assign m_tvalid = meta[STAGES].vld;
	assign m_tdata  = {7'd0, meta[STAGES].sat, energy_s16};
	assign m_tlast  = meta[STAGES].last;
endmodule
`default_nettype wire

FILE: design/ece_table.sv
// Per-group coefficient memories: one row of 36 compliance words and a density word.
`default_nettype none
module ece_table #(
	parameter int GROUP_COUNT = ece_pkg::GROUP_COUNT_DEF,
	parameter int AW          = 4
) (
	input  wire logic          clk,
	input  wire logic          c_we,
	input  wire logic [5:0]    c_word,
	input  wire logic          r_we,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [31:0]   wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [31:0]        rd_c [ece_pkg::MAT_WORDS],
	output logic [31:0]        rd_rho
);
	import ece_pkg::*;

	logic [31:0] cmem [GROUP_COUNT][MAT_WORDS];
	logic [31:0] rmem [GROUP_COUNT];

	always_ff @(posedge clk) begin
		if (c_we) begin
			cmem[wr_addr][c_word] <= wr_data;
		end
		if (r_we) begin
			rmem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_c   <= cmem[rd_addr];
			rd_rho <= rmem[rd_addr];
		end
	end
endmodule
`default_nettype wire
